FILE: hdl/md5bc_pkg.sv
// md5bc_pkg: shared types, constants and round functions of the md5 block compressor
// no dependencies; used by every other file of the block
`timescale 1ns / 1ps

package md5bc_pkg;

  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int BLK_WORDS  = 16;
  localparam int IDX_W      = 4;
  localparam int ROUNDS     = 64;
  localparam int ROUND_W    = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [3:0][WORD_W-1:0] word4_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INIT_A = 2'd0,
    REG_INIT_B = 2'd1,
    REG_INIT_C = 2'd2,
    REG_INIT_D = 2'd3
  } cfg_reg_e;

  // standard initial chaining words
  localparam word_t INIT_A_RST = 32'h67452301;
  localparam word_t INIT_B_RST = 32'hefcdab89;
  localparam word_t INIT_C_RST = 32'h98badcfe;
  localparam word_t INIT_D_RST = 32'h10325476;

  // queued word from front to back
  typedef struct packed {
    word_t            word;
    logic [IDX_W-1:0] idx;
    logic             start;
    logic             last;
  } fwd_item_t;

  // sine-derived additive constants
  localparam word_t SINE_TAB [ROUNDS] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts by phase and round within group of four
  localparam logic [4:0] ROT_TAB [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // message word index used by a round
  function automatic logic [IDX_W-1:0] msg_idx(input logic [ROUND_W-1:0] rnd);
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] g;
    r = rnd[IDX_W-1:0];
    case (rnd[ROUND_W-1:ROUND_W-2])
      2'd0:    g = r;
      2'd1:    g = IDX_W'(r * 4'd5 + 4'd1);
      2'd2:    g = IDX_W'(r * 4'd3 + 4'd5);
      default: g = IDX_W'(r * 4'd7);
    endcase
    return g;
  endfunction

  // nonlinear round function
  function automatic word_t round_fn(input logic [1:0] phase, input word_t b,
                                     input word_t c, input word_t d);
    word_t f;
    case (phase)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  // left rotate, amount never zero here
  function automatic word_t rotl32(input word_t x, input logic [4:0] s);
    return (x << s) | (x >> (6'd32 - {1'b0, s}));
  endfunction

endpackage

FILE: hdl/md5bc_if.sv
// md5bc channel interfaces: message words in, digests out, register writes
// depends on md5bc_pkg
`timescale 1ns / 1ps

interface md5bc_in_if;
  import md5bc_pkg::*;
  logic  valid;
  logic  ready;
  word_t message_word;
  logic  new_message;
  modport source (output valid, message_word, new_message, input ready);
  modport sink   (input valid, message_word, new_message, output ready);
endinterface

interface md5bc_out_if;
  import md5bc_pkg::*;
  logic  valid;
  logic  ready;
  word_t digest_a;
  word_t digest_b;
  word_t digest_c;
  word_t digest_d;
  modport source (output valid, digest_a, digest_b, digest_c, digest_d, input ready);
  modport sink   (input valid, digest_a, digest_b, digest_c, digest_d, output ready);
endinterface

interface md5bc_cfg_if;
  import md5bc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/md5bc_front.sv
// md5bc_front: accepts message words, tags each with block position and start/last marks
// depends on md5bc_pkg and md5bc_if
`timescale 1ns / 1ps

module md5bc_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  md5bc_in_if.sink              in_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output md5bc_pkg::fwd_item_t  item_o
);
  import md5bc_pkg::*;

  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] idx;

  // take a word whenever the queue has room
  assign in_i.ready = ~q_full_i;
  assign push_o     = in_i.valid & ~q_full_i;

  // a new message restarts the block position
  assign idx = in_i.new_message ? '0 : cnt_q;

  always_comb begin
    item_o.word  = in_i.message_word;
    item_o.idx   = idx;
    item_o.start = in_i.new_message;
    item_o.last  = (idx == IDX_W'(BLK_WORDS - 1));
    cnt_d        = cnt_q;
    if (push_o) begin
      cnt_d = IDX_W'(idx + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: hdl/md5bc_fifo.sv
// md5bc_fifo: short register queue between the word front end and the round engine
// depends on md5bc_pkg
`timescale 1ns / 1ps

module md5bc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  md5bc_pkg::fwd_item_t  push_item_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  head_valid_o,
  output md5bc_pkg::fwd_item_t  head_item_o
);
  import md5bc_pkg::*;

  fwd_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]    count_q;

  assign full_o       = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_item_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= QPTR_W'(rd_ptr_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        count_q <= (QPTR_W + 1)'(count_q + 1'b1);
      end else if (!push_i && pop_i) begin
        count_q <= (QPTR_W + 1)'(count_q - 1'b1);
      end
    end
  end

endmodule

FILE: hdl/md5bc_engine.sv
// md5bc_engine: block buffer, chaining state, one-round-per-cycle md5 engine, digest register
// depends on md5bc_pkg and md5bc_if
`timescale 1ns / 1ps

module md5bc_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  md5bc_pkg::word4_t     init_i,
  input  logic                  head_valid_i,
  input  md5bc_pkg::fwd_item_t  head_item_i,
  output logic                  pop_o,
  md5bc_out_if.source           out_o
);
  import md5bc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ROUND,
    S_EMIT
  } state_e;

  state_e               state_q, state_d;
  logic [ROUND_W-1:0]   round_q, round_d;
  word4_t               chain_q, chain_d;
  word4_t               work_q, work_d;
  word_t                pre_q, pre_d;
  logic                 out_valid_q, out_valid_d;
  word4_t               dig_q, dig_d;
  word_t                buf_q [BLK_WORDS];

  word4_t               chain_cur;
  logic [ROUND_W-1:0]   round_nxt;
  word_t                f_val;
  word_t                new_b;
  word4_t               chain_sum;

  // words are only taken between blocks, the buffer stays still during rounds
  assign pop_o = (state_q == S_IDLE) && head_valid_i;

  assign chain_cur = head_item_i.start ? init_i : chain_q;
  assign round_nxt = ROUND_W'(round_q + 1'b1);

  // one md5 step: a + M[g] + K[i] was added ahead of time into pre_q
  assign f_val = round_fn(round_q[ROUND_W-1:ROUND_W-2], work_q[1], work_q[2], work_q[3]);
  assign new_b = work_q[1] +
                 rotl32(f_val + pre_q, ROT_TAB[round_q[ROUND_W-1:ROUND_W-2]][round_q[1:0]]);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      chain_sum[k] = chain_q[k] + work_q[k];
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    round_d     = round_q;
    chain_d     = chain_q;
    work_d      = work_q;
    pre_d       = pre_q;
    out_valid_d = out_valid_q;
    dig_d       = dig_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          chain_d = chain_cur;
          if (head_item_i.last) begin
            state_d = S_ROUND;
            round_d = '0;
            work_d  = chain_cur;
            pre_d   = chain_cur[0] + buf_q[msg_idx('0)] + SINE_TAB[0];
          end
        end
      end
      S_ROUND: begin
        work_d[0] = work_q[3];
        work_d[1] = new_b;
        work_d[2] = work_q[1];
        work_d[3] = work_q[2];
        pre_d     = work_q[3] + buf_q[msg_idx(round_nxt)] + SINE_TAB[round_nxt];
        round_d   = round_nxt;
        if (round_q == ROUND_W'(ROUNDS - 1)) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          chain_d     = chain_sum;
          dig_d       = chain_sum;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      round_q     <= '0;
      chain_q     <= {INIT_D_RST, INIT_C_RST, INIT_B_RST, INIT_A_RST};
      work_q      <= '0;
      pre_q       <= '0;
      out_valid_q <= 1'b0;
      dig_q       <= '0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      chain_q     <= chain_d;
      work_q      <= work_d;
      pre_q       <= pre_d;
      out_valid_q <= out_valid_d;
      dig_q       <= dig_d;
    end
  end

  // block buffer
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      buf_q[head_item_i.idx] <= head_item_i.word;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.digest_a = dig_q[0];
  assign out_o.digest_b = dig_q[1];
  assign out_o.digest_c = dig_q[2];
  assign out_o.digest_d = dig_q[3];

endmodule

FILE: hdl/md5bc_engine_top_note.sv
// md5bc_cfg: initial-value register file written over the configuration channel
// depends on md5bc_pkg and md5bc_if
`timescale 1ns / 1ps

module md5bc_cfg (
  input  logic               clk_i,
  input  logic               rst_ni,
  md5bc_cfg_if.sink          cfg_i,
  output md5bc_pkg::word4_t  init_o
);
  import md5bc_pkg::*;

  word4_t init_q, init_d;

  assign cfg_i.ready = 1'b1;
  assign init_o      = init_q;

  // register decode
  always_comb begin
    init_d = init_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_INIT_A: init_d[0] = cfg_i.data;
        REG_INIT_B: init_d[1] = cfg_i.data;
        REG_INIT_C: init_d[2] = cfg_i.data;
        REG_INIT_D: init_d[3] = cfg_i.data;
        default:    init_d    = init_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= {INIT_D_RST, INIT_C_RST, INIT_B_RST, INIT_A_RST};
    end else begin
      init_q <= init_d;
    end
  end

endmodule

FILE: hdl/md5_block_compress_core.sv
// md5_block_compress_core: top level of the md5 block compressor
// depends on md5bc_pkg, md5bc_if, md5bc_front, md5bc_fifo, md5bc_engine, md5bc_cfg
`timescale 1ns / 1ps

// Takes padded message data as 32-bit words, sixteen to a block, and after each
// sixteenth word delivers the four updated chaining words A..D. A word flagged
// new_message reloads the chaining state from the init registers and starts a
// fresh block, dropping any partial one. Words pass through a four-entry queue
// into the round engine, which stores one word per cycle while it is between
// blocks; the sixteenth word starts 64 rounds at one per cycle on a single
// shared round unit, followed by an emit step that adds into the chaining state
// and loads the digest register once the previous digest is taken. The digest
// register lets the next block's words flow in while a result waits to be
// taken. Init register writes take effect at the next new_message word.
module md5_block_compress_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  md5bc_in_if.sink   in_i,
  md5bc_cfg_if.sink  cfg_i,
  md5bc_out_if.source out_o
);
  import md5bc_pkg::*;

  logic       push;
  fwd_item_t  push_item;
  logic       q_full;
  logic       pop;
  logic       head_valid;
  fwd_item_t  head_item;
  word4_t     init_val;

  // word front end
  md5bc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (push_item)
  );

  // decoupling queue
  md5bc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_item_o  (head_item)
  );

  // init registers
  md5bc_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .init_o (init_val)
  );

  // round engine and digest register
  md5bc_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (init_val),
    .head_valid_i (head_valid),
    .head_item_i  (head_item),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

FILE: bench/testbench.sv
// testbench: self-checking bench for md5_block_compress_core, known answers plus random messages
// depends on md5bc_pkg, md5bc_if and the block's rtl; predicts each digest with its own md5 rounds
`timescale 1ns / 1ps

module testbench;
  import md5bc_pkg::*;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } digest_t;

  typedef struct packed {
    word_t   msg;
    logic    start;
    bit      known;
    digest_t dig;
  } dir_row_t;

  localparam int DIR_ROWS = 25;
  localparam int SETTLE_CYCLES = 100;

  // per-step additive constants, step 0 in the top bits
  localparam logic [64*32-1:0] STEP_K = {
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, four per round group, first group in the top bits
  localparam logic [16*5-1:0] ROT_AMT = {
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  md5bc_in_if  in_if ();
  md5bc_out_if out_if ();
  md5bc_cfg_if cfg_if ();

  md5_block_compress_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  always #6 clk_i = ~clk_i;

  // predictor state: init registers, chaining words, block buffer, fill position
  word_t       init_words [4];
  word_t       chain_st [4];
  word_t       block_words [16];
  logic [3:0]  word_pos;

  digest_t     pending_digests [$];
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;
  dir_row_t    dir_rows [DIR_ROWS];

  function automatic word_t rotate_left(word_t x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // store one word; on the sixteenth run 64 steps and fold into the chain
  function automatic bit absorb_word(word_t w, logic start, output digest_t dig);
    word_t       a, b, c, d, f, t;
    int unsigned g, ph;
    dig = '0;
    if (start) begin
      chain_st = init_words;
      word_pos = '0;
    end
    block_words[word_pos] = w;
    if (word_pos != 4'd15) begin
      word_pos = word_pos + 4'd1;
      return 1'b0;
    end
    word_pos = '0;
    a = chain_st[0];
    b = chain_st[1];
    c = chain_st[2];
    d = chain_st[3];
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 5 * i + 1;
        end
        2: begin
          f = b ^ c ^ d;
          g = 3 * i + 5;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotate_left(a + f + block_words[g % 16] + STEP_K[(63 - i) * 32 +: 32],
                          ROT_AMT[(15 - (ph * 4 + i % 4)) * 5 +: 5]);
      a = t;
    end
    chain_st[0] = chain_st[0] + a;
    chain_st[1] = chain_st[1] + b;
    chain_st[2] = chain_st[2] + c;
    chain_st[3] = chain_st[3] + d;
    dig.a = chain_st[0];
    dig.b = chain_st[1];
    dig.c = chain_st[2];
    dig.d = chain_st[3];
    return 1'b1;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len(int unsigned long_max);
    if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
    return $urandom_range(10, long_max);
  endfunction

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // offer one message word, wait for the handshake, then update the prediction
  task automatic send_word(word_t w, logic start, bit known, digest_t known_dig);
    int unsigned gap;
    digest_t     dig;
    gap = (quiet || $urandom_range(0, 99) < 60) ? 0 : idle_len(40);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.message_word <= w;
    in_if.new_message  <= start;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (absorb_word(w, start, dig)) pending_digests.push_back(known ? known_dig : dig);
  endtask

  // one register write; the caller lowers valid after the last one
  task automatic write_init(cfg_reg_e r, word_t v);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= r;
    cfg_if.data  <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    init_words[r] = v;
  endtask

  // wait until the block is idle, then load a new set of init words
  task automatic load_init_words(int unsigned kind);
    word_t v [4];
    for (int j = 0; j < 4; j++) begin
      case (kind)
        0: v[j] = '0;
        1: v[j] = '1;
        2: v[j] = $urandom;
        default: v[j] = '0;
      endcase
    end
    if (kind == 3) begin
      v[0] = INIT_A_RST;
      v[1] = INIT_B_RST;
      v[2] = INIT_C_RST;
      v[3] = INIT_D_RST;
    end
    in_if.valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_init(REG_INIT_A, v[0]);
    write_init(REG_INIT_B, v[1]);
    write_init(REG_INIT_C, v[2]);
    write_init(REG_INIT_D, v[3]);
    cfg_if.valid <= 1'b0;
  endtask

  // mostly whole messages, plus truncated ones, bare continuations and stray starts
  task automatic run_random_phase(int unsigned n_items);
    int unsigned sent, kind, len;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = 16 * $urandom_range(1, 3);
        for (int k = 0; k < len; k++) send_word(pick_word(), k == 0, 1'b0, '0);
      end else if (kind == 7) begin
        len = $urandom_range(1, 15);
        for (int k = 0; k < len; k++) send_word(pick_word(), k == 0, 1'b0, '0);
      end else if (kind == 8) begin
        len = $urandom_range(1, 20);
        for (int k = 0; k < len; k++) send_word(pick_word(), 1'b0, 1'b0, '0);
      end else begin
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          send_word(pick_word(), $urandom_range(0, 3) == 0, 1'b0, '0);
      end
      sent += len;
    end
  endtask

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("%s wrong: expected %h, got %h", name, want, got);
    end
  endtask

  // digest checker, compares each accepted digest with the oldest prediction
  always @(posedge clk_i) begin
    digest_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_digests.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected digest %h %h %h %h", out_if.digest_a, out_if.digest_b,
                   out_if.digest_c, out_if.digest_d);
      end else begin
        want = pending_digests.pop_front();
        check_field("digest_a", want.a, out_if.digest_a);
        check_field("digest_b", want.b, out_if.digest_b);
        check_field("digest_c", want.c, out_if.digest_c);
        check_field("digest_d", want.d, out_if.digest_d);
      end
    end
  end

  // digest back-pressure
  initial begin
    int unsigned hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (quiet) begin
        out_if.ready <= 1'b1;
      end else if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 65) begin
        out_if.ready <= 1'b1;
      end else begin
        hold = idle_len(200) - 1;
        out_if.ready <= 1'b0;
      end
    end
  end

  // hard limit on run time
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

  // main sequence
  initial begin
    in_if.valid        = 1'b0;
    in_if.message_word = '0;
    in_if.new_message  = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = REG_INIT_A;
    cfg_if.data        = '0;

    init_words[REG_INIT_A] = INIT_A_RST;
    init_words[REG_INIT_B] = INIT_B_RST;
    init_words[REG_INIT_C] = INIT_C_RST;
    init_words[REG_INIT_D] = INIT_D_RST;
    chain_st = init_words;
    for (int j = 0; j < 16; j++) block_words[j] = '0;
    word_pos = '0;

    // partial block at the field extremes, then the padded empty message
    // (which drops that partial block), then a partial continuation
    dir_rows = '{
      {32'hffffffff, 1'b1, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h80000001, 1'b0, 1'b0, 128'h0},
      {32'h00000080, 1'b1, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      // digest of the empty message with the standard init words
      {32'h00000000, 1'b0, 1'b1, {32'hd98c1dd4, 32'h04b2008f, 32'h980980e9, 32'h7e42f8ec}},
      {32'hffffffff, 1'b0, 1'b0, 128'h0},
      {32'h00000000, 1'b0, 1'b0, 128'h0},
      {32'haaaaaaaa, 1'b0, 1'b0, 128'h0},
      {32'h55555555, 1'b0, 1'b0, 128'h0},
      {32'hffffffff, 1'b0, 1'b0, 128'h0},
      {32'h00000001, 1'b0, 1'b0, 128'h0}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++)
      send_word(dir_rows[r].msg, dir_rows[r].start, dir_rows[r].known, dir_rows[r].dig);

    // phases: all-zero, all-one, random and standard init words
    for (int p = 0; p < 6; p++) begin
      load_init_words(p < 4 ? p : 2);
      quiet = (p % 3 == 1);
      run_random_phase(300);
    end
    in_if.valid <= 1'b0;

    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/md5bc_pkg.sv
hdl/md5bc_if.sv
hdl/md5bc_front.sv
hdl/md5bc_fifo.sv
hdl/md5bc_engine.sv
hdl/md5bc_engine_top_note.sv
hdl/md5_block_compress_core.sv
bench/testbench.sv
